// ===== rtl/pdr_pkg.sv =====
// Shared types, constants and Q32.32 saturating helpers for the ridge polynomial fitter.
// Used by every module of the block; depends on nothing else.
package pdr_pkg;

    // Fixed-point constants (Q32.32).
    localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] Q_EPS = 64'sd4295;
    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

    // Coefficient storage is sized for the highest supported degree.
    localparam int MAX_DEGREE    = 7;
    localparam int NCOEF         = MAX_DEGREE + 1;
    localparam int REFINE_PASSES = 3;
    localparam int MAX_POINTS_DEF = 256;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_DEGREE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIDGE_WEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_CAP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFINE_MODE   = 8'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_END,
        OP_SQRT_GO,
        OP_SIGMA_GO,
        OP_CDEN_GO,
        OP_PT_LATCH,
        OP_POW_GO,
        OP_EVC_GO,
        OP_EVR_GO,
        OP_TGT_WR,
        OP_STEP_GO,
        OP_DUAL_GO,
        OP_GRAD_GO,
        OP_CG_GO,
        OP_CDIV_GO,
        OP_FIT_CLR,
        OP_ITER_CLR,
        OP_RC_COPY,
        OP_RSC_GO,
        OP_EMIT
    } t_op;

    // Controller states.
    typedef enum logic [5:0] {
        S_IDLE,
        S_SQ_GO,
        S_SQ_WAIT,
        S_SIG_GO,
        S_SIG_WAIT,
        S_CD_GO,
        S_CD_WAIT,
        S_PASS,
        S_FIT_INIT,
        S_ITER_INIT,
        S_PT_READ,
        S_PT_LATCH,
        S_POW_GO,
        S_POW_WAIT,
        S_EV_GO,
        S_EV_WAIT,
        S_TGT_WR,
        S_STEP_GO,
        S_STEP_WAIT,
        S_DUAL_GO,
        S_DUAL_WAIT,
        S_GRAD_GO,
        S_GRAD_WAIT,
        S_CG_GO,
        S_CG_WAIT,
        S_CDIV_GO,
        S_CDIV_WAIT,
        S_ITER_END,
        S_FIT_END,
        S_RSC_GO,
        S_RSC_WAIT,
        S_NEXT,
        S_EMIT,
        S_END
    } t_state;

    // Command from controller to datapath.
    typedef struct packed {
        t_op        op;
        logic [2:0] j;
        logic [1:0] shift;
        logic       use_y;
        logic       first_iter;
        logic       tail;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic delta_small;
        logic pt_last;
    } t_stat;

    // Saturating add.
    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    // Saturating subtract.
    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    // Magnitude as an unsigned 64-bit value.
    function automatic logic [63:0] mag64(logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // Signed value from a magnitude, saturated.
    function automatic logic signed [63:0] from_mag(logic [63:0] m, logic neg,
                                                    logic ovf);
        if (neg) begin
            if (ovf || m[63]) return Q_MIN;
            return 64'sd0 - $signed(m);
        end
        if (ovf || m[63]) return Q_MAX;
        return $signed(m);
    endfunction

endpackage

// ===== rtl/pdr_mul.sv =====
// Multi-cycle Q32.32 multiplier: four 32x32 partial products, round to nearest, saturate.
// Depends on pdr_pkg.
module pdr_mul import pdr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_p
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [1:0]   r_k;
    logic         r_run, r_fin, r_done;
    logic signed [63:0] r_p;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // Partial product selected by the step counter.
    always_comb begin
        pa = r_k[1] ? r_ua[63:32] : r_ua[31:0];
        pb = r_k[0] ? r_ub[63:32] : r_ub[31:0];
        pp = pa * pb;
        case (r_k)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // Control sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_k   <= 2'd0;
            end else if (r_run) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operands, accumulator and result; the rounding half is preloaded.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= mag64(i_a);
            r_ub  <= mag64(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= 128'h8000_0000;
        end else if (r_run) begin
            r_acc <= r_acc + pp_sh;
        end else if (r_fin) begin
            r_p <= from_mag(r_acc[95:32], r_neg, |r_acc[127:96]);
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== rtl/pdr_div.sv =====
// Bit-serial Q32.32 divider: one quotient bit per cycle over 96 steps, truncating, saturated.
// Depends on pdr_pkg.
module pdr_div import pdr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_q
);

    logic [95:0] r_num;
    logic [63:0] r_rem, r_q, r_d;
    logic        r_ovf, r_neg;
    logic [6:0]  r_cnt;
    logic        r_run, r_fin, r_done;
    logic signed [63:0] r_res;

    logic [64:0] rs, rs_sub;
    logic        ge;

    // One restoring step.
    always_comb begin
        rs     = {r_rem, r_num[95]};
        rs_sub = rs - {1'b0, r_d};
        ge     = (rs >= {1'b0, r_d});
    end

    // Control sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_b == 64'sd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                    r_cnt <= 7'd95;
                end
            end else if (r_run) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and quotient registers; a zero divisor saturates by the dividend's sign, and zero over zero gives zero.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {mag64(i_a), 32'd0};
            r_d   <= mag64(i_b);
            r_rem <= 64'd0;
            r_q   <= 64'd0;
            r_ovf <= 1'b0;
            r_neg <= i_a[63] ^ i_b[63];
            if (i_b == 64'sd0) begin
                if (i_a == 64'sd0)  r_res <= 64'sd0;
                else if (i_a[63])   r_res <= Q_MIN;
                else                r_res <= Q_MAX;
            end
        end else if (r_run) begin
            r_num <= {r_num[94:0], 1'b0};
            r_rem <= ge ? rs_sub[63:0] : rs[63:0];
            r_ovf <= r_ovf | r_q[63];
            r_q   <= {r_q[62:0], ge};
        end else if (r_fin) begin
            r_res <= from_mag(r_q, r_neg, r_ovf);
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

// ===== rtl/pdr_isqrt.sv =====
// Step size unit: tau = floor(2^32 / sqrt(n)) found one bit at a time, each by a square step and a compare step.
// Depends on pdr_pkg.
module pdr_isqrt import pdr_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   i_n,
    output logic                              o_done,
    output logic signed [63:0]                o_tau
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 64 + CW;

    logic [CW-1:0] r_n;
    logic [31:0]   r_t;
    logic [63:0]   r_sq;
    logic [4:0]    r_k;
    logic          r_run, r_ph, r_done;

    logic [31:0] cand;
    logic [PW-1:0] prod;
    logic          fits;

    // Candidate t with bit k set; it fits when cand^2 * n <= 2^64.
    always_comb begin
        cand = r_t | (32'd1 << r_k);
        prod = PW'(r_sq) * PW'(r_n);
        fits = (prod <= (PW'(1) << 64));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_ph   <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_ph  <= 1'b0;
                r_k   <= 5'd31;
            end else if (r_run) begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    r_k <= r_k - 5'd1;
                    if (r_k == 5'd0) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Square first, then scale by n and compare.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_n;
            r_t <= 32'd0;
        end else if (r_run) begin
            if (!r_ph) r_sq <= cand * cand;
            else if (fits) r_t <= cand;
        end
    end

    assign o_done = r_done;
    assign o_tau  = (r_n <= CW'(1)) ? Q_ONE : $signed({32'd0, r_t});

endmodule

// ===== rtl/pdr_datapath.sv =====
// Datapath of the fitter: point memories, coefficient registers and shared arithmetic units.
// Depends on pdr_pkg, pdr_mul, pdr_div and pdr_isqrt.
module pdr_datapath import pdr_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cmd                             i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]    i_addr,
    input  logic signed [31:0]               i_x_value,
    input  logic signed [31:0]               i_y_value,
    input  logic [31:0]                      i_ridge_weight,
    output t_stat                            o_stat,
    output logic                             o_strobe,
    output logic [2:0]                       o_coefficient_index,
    output logic signed [63:0]               o_coefficient,
    output logic                             o_last_coefficient,
    output logic                             o_points_dropped
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Point stores.
    logic [31:0]        x_mem [MAX_POINTS];
    logic [31:0]        y_mem [MAX_POINTS];
    logic signed [63:0] t_mem [MAX_POINTS];
    logic signed [63:0] d_mem [MAX_POINTS];
    logic [31:0]        r_xrd, r_yrd;
    logic signed [63:0] r_trd, r_drd;

    // Working registers.
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic signed [63:0] r_c  [NCOEF];
    logic signed [63:0] r_rc [NCOEF];
    logic signed [63:0] r_g  [NCOEF];
    logic signed [63:0] r_pw [NCOEF];
    logic signed [63:0] r_x, r_y, r_t, r_d, r_acc, r_prod, r_dual, r_delta;
    logic signed [63:0] r_tau, r_sigma, r_dden, r_cden;
    t_op                r_mdest, r_ddest;
    logic [2:0]         r_mj, r_dj;
    logic [AW-1:0]      r_daddr;
    logic               r_strobe, r_out_last, r_out_drop;
    logic [2:0]         r_out_idx;
    logic signed [63:0] r_out_coef;

    // Unit handshakes.
    logic               mul_start, div_start, sq_start;
    logic signed [63:0] mul_a, mul_b, div_a, div_b;
    logic               mul_done, div_done, sq_done;
    logic signed [63:0] mul_p, div_q, sq_tau;

    logic [CW-1:0] cnt_m1;
    logic          load_ok;

    pdr_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_p    (mul_p)
    );

    pdr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_a    (div_a),
        .i_b    (div_b),
        .o_done (div_done),
        .o_q    (div_q)
    );

    pdr_isqrt #(.MAX_POINTS(MAX_POINTS)) u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_n    (r_count),
        .o_done (sq_done),
        .o_tau  (sq_tau)
    );

    // Operand selection for the shared units.
    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        sq_start  = 1'b0;
        mul_a     = 64'sd0;
        mul_b     = 64'sd0;
        div_a     = 64'sd0;
        div_b     = 64'sd0;
        case (i_cmd.op)
            OP_SQRT_GO: sq_start = 1'b1;
            OP_SIGMA_GO: begin
                div_start = 1'b1;
                div_a     = Q_ONE;
                div_b     = r_tau;
            end
            OP_CDEN_GO: begin
                mul_start = 1'b1;
                mul_a     = r_tau;
                mul_b     = $signed({16'd0, i_ridge_weight, 16'd0});
            end
            OP_POW_GO: begin
                mul_start = 1'b1;
                mul_a     = (i_cmd.j == 3'd1) ? Q_ONE : r_prod;
                mul_b     = r_x;
            end
            OP_EVC_GO: begin
                mul_start = 1'b1;
                mul_a     = r_c[i_cmd.j];
                mul_b     = r_pw[i_cmd.j];
            end
            OP_EVR_GO: begin
                mul_start = 1'b1;
                mul_a     = r_rc[i_cmd.j];
                mul_b     = r_pw[i_cmd.j];
            end
            OP_STEP_GO: begin
                mul_start = 1'b1;
                mul_a     = r_sigma;
                mul_b     = sat_sub(r_acc, r_t);
            end
            OP_DUAL_GO: begin
                div_start = 1'b1;
                div_a     = sat_add(r_d, r_prod);
                div_b     = r_dden;
            end
            OP_GRAD_GO: begin
                mul_start = 1'b1;
                mul_a     = r_pw[i_cmd.j];
                mul_b     = r_dual;
            end
            OP_CG_GO: begin
                mul_start = 1'b1;
                mul_a     = r_tau;
                mul_b     = r_g[i_cmd.j];
            end
            OP_CDIV_GO: begin
                div_start = 1'b1;
                div_a     = sat_sub(r_c[i_cmd.j], r_prod);
                div_b     = r_cden;
            end
            OP_RSC_GO: begin
                mul_start = 1'b1;
                mul_a     = r_c[i_cmd.j];
                mul_b     = Q_ONE >>> i_cmd.shift;
            end
            default: ;
        endcase
    end

    // Point count and capacity check.
    assign load_ok = (r_count < CW'(MAX_POINTS));
    assign cnt_m1  = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.op == OP_LOAD) begin
            if (load_ok) r_count <= r_count + CW'(1);
            else         r_ovf   <= 1'b1;
        end else if (i_cmd.op == OP_END) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end
    end

    // Memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && load_ok) begin
            x_mem[r_count[AW-1:0]] <= i_x_value;
            y_mem[r_count[AW-1:0]] <= i_y_value;
        end
        if (i_cmd.op == OP_TGT_WR) t_mem[i_addr] <= sat_sub(r_y, r_acc);
        if (div_done && r_ddest == OP_DUAL_GO) d_mem[r_daddr] <= div_q;
        r_xrd <= x_mem[i_addr];
        r_yrd <= y_mem[i_addr];
        r_trd <= t_mem[i_addr];
        r_drd <= d_mem[i_addr];
    end

    // Arithmetic state and unit write-back.
    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_mdest <= i_cmd.op;
            r_mj    <= i_cmd.j;
        end
        if (div_start) begin
            r_ddest <= i_cmd.op;
            r_dj    <= i_cmd.j;
            r_daddr <= i_addr;
        end
        if (sq_done) r_tau <= sq_tau;

        case (i_cmd.op)
            OP_PT_LATCH: begin
                r_x     <= $signed({{16{r_xrd[31]}}, r_xrd, 16'd0});
                r_y     <= $signed({{16{r_yrd[31]}}, r_yrd, 16'd0});
                r_t     <= i_cmd.use_y ? $signed({{16{r_yrd[31]}}, r_yrd, 16'd0}) : r_trd;
                r_d     <= i_cmd.first_iter ? 64'sd0 : r_drd;
                r_pw[0] <= Q_ONE;
                r_acc   <= 64'sd0;
            end
            OP_FIT_CLR: begin
                for (int k = 0; k < NCOEF; k++) r_c[k] <= 64'sd0;
            end
            OP_ITER_CLR: begin
                for (int k = 0; k < NCOEF; k++) r_g[k] <= 64'sd0;
                r_delta <= 64'sd0;
            end
            OP_RC_COPY: begin
                for (int k = 0; k < NCOEF; k++) r_rc[k] <= r_c[k];
            end
            default: ;
        endcase

        if (mul_done) begin
            r_prod <= mul_p;
            case (r_mdest)
                OP_POW_GO:  r_pw[r_mj] <= mul_p;
                OP_EVC_GO,
                OP_EVR_GO:  r_acc <= sat_add(r_acc, mul_p);
                OP_GRAD_GO: r_g[r_mj] <= sat_add(r_g[r_mj], mul_p);
                OP_CDEN_GO: r_cden <= sat_add(Q_ONE, mul_p);
                OP_RSC_GO:  r_rc[r_mj] <= sat_add(r_rc[r_mj], mul_p);
                default: ;
            endcase
        end

        if (div_done) begin
            case (r_ddest)
                OP_SIGMA_GO: begin
                    r_sigma <= div_q;
                    r_dden  <= sat_add(Q_ONE, div_q);
                end
                OP_DUAL_GO: r_dual <= div_q;
                OP_CDIV_GO: begin
                    r_c[r_dj] <= div_q;
                    r_delta   <= sat_add(r_delta, $signed(mag64(sat_sub(div_q, r_c[r_dj]))));
                end
                default: ;
            endcase
        end
    end

    // Result register: one coefficient per emit command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == OP_EMIT);
        end
        if (i_cmd.op == OP_EMIT) begin
            r_out_idx  <= i_cmd.j;
            r_out_coef <= r_rc[i_cmd.j];
            r_out_last <= i_cmd.tail;
            r_out_drop <= r_ovf;
        end
    end

    always_comb begin
        o_stat.mul_done    = mul_done;
        o_stat.div_done    = div_done;
        o_stat.sqrt_done   = sq_done;
        o_stat.delta_small = (r_delta < Q_EPS);
        o_stat.pt_last     = (i_addr == cnt_m1[AW-1:0]);
    end

    assign o_strobe            = r_strobe;
    assign o_coefficient_index = r_out_idx;
    assign o_coefficient       = r_out_coef;
    assign o_last_coefficient  = r_out_last;
    assign o_points_dropped    = r_out_drop;

endmodule

// ===== rtl/pdr_ctrl.sv =====
// Controller of the fitter: sequences loading, step sizes, iterations, refinement and output.
// Depends on pdr_pkg.
module pdr_ctrl import pdr_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_last_point,
    input  logic [2:0]                     i_fit_degree,
    input  logic [9:0]                     i_iteration_cap,
    input  logic                           i_refine_mode,
    input  t_stat                          i_stat,
    output t_cmd                           o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]  o_addr,
    output logic                           o_busy
);

    localparam int AW = $clog2(MAX_POINTS);

    t_state        r_state, n_state;
    logic [2:0]    r_j, n_j;
    logic [AW-1:0] r_i, n_i;
    logic [9:0]    r_it, n_it;
    logic [1:0]    r_pass, n_pass;
    logic          r_tgt, n_tgt;

    logic [2:0]    deg;
    logic          j_end;

    // Degree zero is fitted as degree one.
    assign deg   = (i_fit_degree == 3'd0) ? 3'd1 : i_fit_degree;
    assign j_end = (r_j == deg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= 3'd0;
            r_i     <= '0;
            r_it    <= 10'd0;
            r_pass  <= 2'd0;
            r_tgt   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_i     <= n_i;
            r_it    <= n_it;
            r_pass  <= n_pass;
            r_tgt   <= n_tgt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state          = r_state;
        n_j              = r_j;
        n_i              = r_i;
        n_it             = r_it;
        n_pass           = r_pass;
        n_tgt            = r_tgt;
        o_cmd.op         = OP_NONE;
        o_cmd.j          = r_j;
        o_cmd.shift      = r_pass - 2'd1;
        o_cmd.use_y      = (r_pass == 2'd0);
        o_cmd.first_iter = (r_it == 10'd0);
        o_cmd.tail       = j_end;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    if (i_last_point) begin
                        n_pass  = 2'd0;
                        n_state = S_SQ_GO;
                    end
                end
            end
            S_SQ_GO: begin
                o_cmd.op = OP_SQRT_GO;
                n_state  = S_SQ_WAIT;
            end
            S_SQ_WAIT: if (i_stat.sqrt_done) n_state = S_SIG_GO;
            S_SIG_GO: begin
                o_cmd.op = OP_SIGMA_GO;
                n_state  = S_SIG_WAIT;
            end
            S_SIG_WAIT: if (i_stat.div_done) n_state = S_CD_GO;
            S_CD_GO: begin
                o_cmd.op = OP_CDEN_GO;
                n_state  = S_CD_WAIT;
            end
            S_CD_WAIT: if (i_stat.mul_done) n_state = S_PASS;
            // Refinement passes first rebuild the residual targets.
            S_PASS: begin
                if (r_pass == 2'd0) begin
                    n_state = S_FIT_INIT;
                end else begin
                    n_tgt   = 1'b1;
                    n_i     = '0;
                    n_state = S_PT_READ;
                end
            end
            S_FIT_INIT: begin
                o_cmd.op = OP_FIT_CLR;
                n_it     = 10'd0;
                n_state  = (i_iteration_cap == 10'd0) ? S_FIT_END : S_ITER_INIT;
            end
            S_ITER_INIT: begin
                o_cmd.op = OP_ITER_CLR;
                n_i      = '0;
                n_tgt    = 1'b0;
                n_state  = S_PT_READ;
            end
            S_PT_READ: n_state = S_PT_LATCH;
            S_PT_LATCH: begin
                o_cmd.op = OP_PT_LATCH;
                n_j      = 3'd1;
                n_state  = S_POW_GO;
            end
            // Powers of x for this point.
            S_POW_GO: begin
                o_cmd.op = OP_POW_GO;
                n_state  = S_POW_WAIT;
            end
            S_POW_WAIT: begin
                if (i_stat.mul_done) begin
                    if (j_end) begin
                        n_j     = 3'd0;
                        n_state = S_EV_GO;
                    end else begin
                        n_j     = r_j + 3'd1;
                        n_state = S_POW_GO;
                    end
                end
            end
            // Polynomial value with fit or refined coefficients.
            S_EV_GO: begin
                o_cmd.op = r_tgt ? OP_EVR_GO : OP_EVC_GO;
                n_state  = S_EV_WAIT;
            end
            S_EV_WAIT: begin
                if (i_stat.mul_done) begin
                    if (j_end) begin
                        n_state = r_tgt ? S_TGT_WR : S_STEP_GO;
                    end else begin
                        n_j     = r_j + 3'd1;
                        n_state = S_EV_GO;
                    end
                end
            end
            S_TGT_WR: begin
                o_cmd.op = OP_TGT_WR;
                if (i_stat.pt_last) begin
                    n_state = S_FIT_INIT;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_PT_READ;
                end
            end
            // Dual update for this point.
            S_STEP_GO: begin
                o_cmd.op = OP_STEP_GO;
                n_state  = S_STEP_WAIT;
            end
            S_STEP_WAIT: if (i_stat.mul_done) n_state = S_DUAL_GO;
            S_DUAL_GO: begin
                o_cmd.op = OP_DUAL_GO;
                n_state  = S_DUAL_WAIT;
            end
            S_DUAL_WAIT: begin
                if (i_stat.div_done) begin
                    n_j     = 3'd0;
                    n_state = S_GRAD_GO;
                end
            end
            // Gradient accumulation for this point.
            S_GRAD_GO: begin
                o_cmd.op = OP_GRAD_GO;
                n_state  = S_GRAD_WAIT;
            end
            S_GRAD_WAIT: begin
                if (i_stat.mul_done) begin
                    if (!j_end) begin
                        n_j     = r_j + 3'd1;
                        n_state = S_GRAD_GO;
                    end else if (i_stat.pt_last) begin
                        n_j     = 3'd0;
                        n_state = S_CG_GO;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_PT_READ;
                    end
                end
            end
            // Primal update of every coefficient.
            S_CG_GO: begin
                o_cmd.op = OP_CG_GO;
                n_state  = S_CG_WAIT;
            end
            S_CG_WAIT: if (i_stat.mul_done) n_state = S_CDIV_GO;
            S_CDIV_GO: begin
                o_cmd.op = OP_CDIV_GO;
                n_state  = S_CDIV_WAIT;
            end
            S_CDIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (j_end) begin
                        n_state = S_ITER_END;
                    end else begin
                        n_j     = r_j + 3'd1;
                        n_state = S_CG_GO;
                    end
                end
            end
            S_ITER_END: begin
                n_it = r_it + 10'd1;
                if (i_stat.delta_small ||
                    ({1'b0, r_it} + 11'd1 == {1'b0, i_iteration_cap})) begin
                    n_state = S_FIT_END;
                end else begin
                    n_state = S_ITER_INIT;
                end
            end
            // Base fit is copied; each refinement adds its scaled correction.
            S_FIT_END: begin
                if (r_pass == 2'd0) begin
                    o_cmd.op = OP_RC_COPY;
                    n_state  = S_NEXT;
                end else begin
                    n_j     = 3'd0;
                    n_state = S_RSC_GO;
                end
            end
            S_RSC_GO: begin
                o_cmd.op = OP_RSC_GO;
                n_state  = S_RSC_WAIT;
            end
            S_RSC_WAIT: begin
                if (i_stat.mul_done) begin
                    if (j_end) begin
                        n_state = S_NEXT;
                    end else begin
                        n_j     = r_j + 3'd1;
                        n_state = S_RSC_GO;
                    end
                end
            end
            S_NEXT: begin
                if (i_refine_mode && (r_pass != 2'(REFINE_PASSES))) begin
                    n_pass  = r_pass + 2'd1;
                    n_state = S_PASS;
                end else begin
                    n_j     = 3'd0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                if (j_end) n_state = S_END;
                else       n_j     = r_j + 3'd1;
            end
            S_END: begin
                o_cmd.op = OP_END;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_addr = r_i;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/primal_dual_ridge_poly_fit_top.sv =====
// Top level of the ridge polynomial fitter: configuration registers, controller and datapath.
// Depends on pdr_pkg, pdr_ctrl and pdr_datapath.
//
// Usage. Points are transferred on the command channel: a point is taken at a clock edge
// where i_start is high and o_busy is low. While loading, one point is taken every cycle
// and stored at the next free place of the point memory; points beyond MAX_POINTS are
// dropped and reported with the results. A point with i_last_point set starts the fit and
// raises o_busy. The fit runs iteration_cap iterations at most (fewer once the coefficient
// change falls below 1e-6), three more times in refine mode. In an iteration each point of a
// degree d fit needs 3d+3 multiplies and one divide through the shared bit-serial divider.
// Each refinement pass first rebuilds the residual targets. The d+1 coefficients then appear
// on consecutive cycles, each for one cycle marked by o_strobe, the last one flagged; the
// receiver cannot stall them. o_busy falls in the cycle after the one that carries the last
// coefficient. Configuration writes on the i_cfg channel are always ready; they are to be made
// while the block is idle, which the block itself does not enforce. Synchronous reset clears
// the point count and restores the register defaults; no memory clearing pass is needed.
module primal_dual_ridge_poly_fit_top import pdr_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic signed [31:0]    i_x_value,
    input  logic signed [31:0]    i_y_value,
    input  logic                  i_last_point,
    output logic                  o_strobe,
    output logic [2:0]            o_coefficient_index,
    output logic signed [63:0]    o_coefficient,
    output logic                  o_last_coefficient,
    output logic                  o_points_dropped,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [2:0]  r_fit_degree;
    logic [31:0] r_ridge_weight;
    logic [9:0]  r_iteration_cap;
    logic        r_refine_mode;

    t_cmd          cmd;
    t_stat         stat;
    logic [AW-1:0] addr;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_degree    <= 3'd3;
            r_ridge_weight  <= 32'd65536;
            r_iteration_cap <= 10'd100;
            r_refine_mode   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIT_DEGREE:    r_fit_degree    <= i_cfg_data[2:0];
                CFG_RIDGE_WEIGHT:  r_ridge_weight  <= i_cfg_data;
                CFG_ITERATION_CAP: r_iteration_cap <= i_cfg_data[9:0];
                CFG_REFINE_MODE:   r_refine_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    pdr_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_last_point   (i_last_point),
        .i_fit_degree   (r_fit_degree),
        .i_iteration_cap(r_iteration_cap),
        .i_refine_mode  (r_refine_mode),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_addr         (addr),
        .o_busy         (o_busy)
    );

    pdr_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_addr             (addr),
        .i_x_value          (i_x_value),
        .i_y_value          (i_y_value),
        .i_ridge_weight     (r_ridge_weight),
        .o_stat             (stat),
        .o_strobe           (o_strobe),
        .o_coefficient_index(o_coefficient_index),
        .o_coefficient      (o_coefficient),
        .o_last_coefficient (o_last_coefficient),
        .o_points_dropped   (o_points_dropped)
    );

endmodule

// ===== test/tb_primal_dual_ridge_poly_fit_top.sv =====
// Testbench for the ridge polynomial fitter: directed and random point sets
// checked against a Q32.32 predictor of the fit. Depends on pdr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_primal_dual_ridge_poly_fit_top import pdr_pkg::*; ();

    localparam int  STORE_DEPTH = 256;
    localparam longint CYCLE_LIMIT = 8_000_000;

    typedef struct {
        logic [2:0]         index;
        logic signed [63:0] coef;
        logic               last;
        logic               dropped;
    } t_coef_result;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               last_point;
    logic               strobe;
    logic [2:0]         coefficient_index;
    logic signed [63:0] coefficient;
    logic               last_coefficient;
    logic               points_dropped;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]        cfg_data;

    // Predictor state and its copy of the registers.
    logic signed [63:0] pts_x [STORE_DEPTH];
    logic signed [63:0] pts_y [STORE_DEPTH];
    logic signed [63:0] target [STORE_DEPTH];
    logic signed [63:0] dual [STORE_DEPTH];
    logic signed [63:0] coef [8];
    logic signed [63:0] prev_coef [8];
    logic signed [63:0] grad [8];
    logic signed [63:0] refined [8];
    int                 stored_points;
    logic               dropped_flag;
    logic [2:0]         degree_reg;
    logic [31:0]        ridge_reg;
    logic [9:0]         cap_reg;
    logic               refine_reg;

    t_coef_result       expected_coefs[$];
    int                 error_count;
    int                 sender_idle_pct;
    longint             cycle_count;

    primal_dual_ridge_poly_fit_top u_top (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_start             (start),
        .o_busy              (busy),
        .i_x_value           (x_value),
        .i_y_value           (y_value),
        .i_last_point        (last_point),
        .o_strobe            (strobe),
        .o_coefficient_index (coefficient_index),
        .o_coefficient       (coefficient),
        .o_last_coefficient  (last_coefficient),
        .o_points_dropped    (points_dropped),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fixed-point arithmetic of the fit.
    function automatic logic signed [63:0] to_signed(logic [63:0] m, logic neg, logic ovf);
        if (neg) begin
            if (ovf || m[63]) return Q_MIN;
            return 64'sd0 - $signed(m);
        end
        if (ovf || m[63]) return Q_MAX;
        return $signed(m);
    endfunction

    function automatic logic [63:0] abs_of(logic signed [63:0] a);
        return a[63] ? 64'd0 - a : a;
    endfunction

    function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] p;
        logic         neg;
        neg = a[63] != b[63];
        p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
        p = p + 128'h8000_0000;
        if (p[127:96] != 0) return to_signed(64'd0, neg, 1'b1);
        return to_signed(p[95:32], neg, 1'b0);
    endfunction

    function automatic logic signed [63:0] q_div(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] q;
        logic         neg;
        neg = a[63] != b[63];
        if (b == 0) begin
            if (a == 0) return 64'sd0;
            return a[63] ? Q_MIN : Q_MAX;
        end
        q = {32'd0, abs_of(a), 32'd0} / {64'd0, abs_of(b)};
        return to_signed(q[63:0], neg, q[127:64] != 0);
    endfunction

    // Step size: floor(2^32 / sqrt(n)).
    function automatic logic signed [63:0] step_size(int n);
        logic [63:0] lim;
        logic [63:0] t;
        logic [63:0] c;
        if (n <= 1) return Q_ONE;
        lim = 64'hFFFF_FFFF_FFFF_FFFF / n + (((n & (n - 1)) == 0) ? 64'd1 : 64'd0);
        t = 0;
        for (int k = 31; k >= 0; k--) begin
            c = t | (64'd1 << k);
            if (c * c <= lim) t = c;
        end
        return $signed(t);
    endfunction

    function automatic logic signed [63:0] poly_at(logic signed [63:0] c[8], int m,
                                                    logic signed [63:0] x);
        logic signed [63:0] acc;
        logic signed [63:0] xp;
        acc = 0;
        xp = Q_ONE;
        for (int j = 0; j < m; j++) begin
            acc = q_add(acc, q_mul(c[j], xp));
            xp = q_mul(xp, x);
        end
        return acc;
    endfunction

    // One primal-dual fit of the targets into coef.
    task automatic solve_ridge(int n, int m);
        logic signed [63:0] tau;
        logic signed [63:0] sigma;
        logic signed [63:0] dual_den;
        logic signed [63:0] coef_den;
        logic signed [63:0] delta;
        logic signed [63:0] xp;
        logic signed [63:0] diff;
        tau = step_size(n);
        sigma = q_div(Q_ONE, tau);
        dual_den = q_add(Q_ONE, sigma);
        coef_den = q_add(Q_ONE, q_mul(tau, $signed({16'd0, ridge_reg, 16'd0})));
        for (int i = 0; i < STORE_DEPTH; i++) dual[i] = 0;
        for (int j = 0; j < 8; j++) coef[j] = 0;
        for (int it = 0; it < cap_reg; it++) begin
            prev_coef = coef;
            for (int i = 0; i < n; i++)
                dual[i] = q_div(q_add(dual[i], q_mul(sigma,
                          q_sub(poly_at(coef, m, pts_x[i]), target[i]))), dual_den);
            for (int j = 0; j < 8; j++) grad[j] = 0;
            for (int i = 0; i < n; i++) begin
                xp = Q_ONE;
                for (int j = 0; j < m; j++) begin
                    grad[j] = q_add(grad[j], q_mul(xp, dual[i]));
                    xp = q_mul(xp, pts_x[i]);
                end
            end
            delta = 0;
            for (int j = 0; j < m; j++) begin
                coef[j] = q_div(q_sub(coef[j], q_mul(tau, grad[j])), coef_den);
                diff = $signed(abs_of(q_sub(coef[j], prev_coef[j])));
                delta = q_add(delta, diff);
            end
            if (delta < Q_EPS) break;
        end
    endtask

    // Point store and, on the last point, the expected coefficients.
    task automatic predict_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
        int m;
        int d;
        t_coef_result r;
        if (stored_points < STORE_DEPTH) begin
            pts_x[stored_points] = {{16{x[31]}}, x, 16'd0};
            pts_y[stored_points] = {{16{y[31]}}, y, 16'd0};
            stored_points++;
        end else begin
            dropped_flag = 1'b1;
        end
        if (!last) return;
        d = int'(degree_reg);
        if (d < 1) d = 1;
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        m = d + 1;
        for (int i = 0; i < stored_points; i++) target[i] = pts_y[i];
        solve_ridge(stored_points, m);
        refined = coef;
        if (refine_reg) begin
            for (int p = 0; p < REFINE_PASSES; p++) begin
                for (int i = 0; i < stored_points; i++)
                    target[i] = q_sub(pts_y[i], poly_at(refined, m, pts_x[i]));
                solve_ridge(stored_points, m);
                for (int j = 0; j < m; j++)
                    refined[j] = q_add(refined[j], q_mul(coef[j], Q_ONE >>> p));
            end
        end
        for (int j = 0; j < m; j++) begin
            r.index = j[2:0];
            r.coef = refined[j];
            r.last = (j == m - 1);
            r.dropped = dropped_flag;
            expected_coefs.push_back(r);
        end
        stored_points = 0;
        dropped_flag = 1'b0;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Result checker: every strobe is compared with the oldest expectation.
    always @(posedge clk) begin
        t_coef_result e;
        if (rst_n && strobe) begin
            if (expected_coefs.size() == 0) begin
                report_mismatch($sformatf("unexpected coefficient %0d", coefficient_index));
            end else begin
                e = expected_coefs.pop_front();
                if (coefficient_index !== e.index)
                    report_mismatch($sformatf("index %0d, want %0d", coefficient_index, e.index));
                if (coefficient !== e.coef)
                    report_mismatch($sformatf("coef[%0d] %h, want %h", e.index,
                                              coefficient, e.coef));
                if (last_coefficient !== e.last)
                    report_mismatch($sformatf("last flag %b, want %b", last_coefficient, e.last));
                if (points_dropped !== e.dropped)
                    report_mismatch($sformatf("dropped flag %b, want %b", points_dropped,
                                              e.dropped));
            end
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one point; start stays high into the next transfer unless a gap follows.
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
        @(negedge clk);
        start <= 1'b1;
        x_value <= x;
        y_value <= y;
        last_point <= last;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        predict_point(x, y, last);
        if ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    // Waits until every expected coefficient has come and the block is idle.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_coefs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        case (index)
            CFG_FIT_DEGREE:    degree_reg = data[2:0];
            CFG_RIDGE_WEIGHT:  ridge_reg = data;
            CFG_ITERATION_CAP: cap_reg = data[9:0];
            CFG_REFINE_MODE:   refine_reg = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int deg, logic [31:0] ridge, int cap, logic refine);
        write_register(CFG_FIT_DEGREE, deg);
        write_register(CFG_RIDGE_WEIGHT, ridge);
        write_register(CFG_ITERATION_CAP, cap);
        write_register(CFG_REFINE_MODE, 32'(refine));
    endtask

    function automatic logic signed [31:0] rand_sample();
        if ($urandom_range(3) == 0) return $signed($urandom);
        return $signed($urandom_range(32'h0004_0000) - 32'h0002_0000);
    endfunction

    // Field extremes at the highest degree with refinement.
    task automatic test_field_extremes();
        configure(7, 0, 2, 1'b1);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(-1, 1, 1'b1);
        drain_results();
    endtask

    // Degree zero taken as one, full ridge weight, largest cap on one point; zero cap; unknown index.
    task automatic test_register_limits();
        configure(0, 32'hFFFF_FFFF, 1023, 1'b0);
        send_point(32'sh0001_0000, 32'sh0002_0000, 1'b1);
        drain_results();
        configure(2, 32'h0000_8000, 0, 1'b1);
        send_point(32'sh0001_0000, 32'sh0003_0000, 1'b0);
        send_point(32'shFFFF_0000, 32'sh0001_8000, 1'b1);
        drain_results();
        // A write beyond the register list must change nothing.
        write_register(CFG_IDX_W'(CFG_REFINE_MODE + 8'd1), 32'hFFFF_FFFF);
        configure(3, 32'h0001_0000, 3, 1'b1);
        send_point(32'sh0000_8000, 32'sh0001_0000, 1'b0);
        send_point(32'sh0002_0000, 32'shFFFF_0000, 1'b1);
        drain_results();
    endtask

    // A full store: the next points are dropped and flagged, the last one too, which still starts the fit.
    task automatic test_store_full();
        configure(1, 32'h0001_0000, 1, 1'b0);
        for (int i = 0; i <= STORE_DEPTH + 1; i++)
            send_point($signed($urandom_range(32'h0002_0000) - 32'h0001_0000),
                       rand_sample(), i == STORE_DEPTH + 1);
        drain_results();
        // The flag must clear for the next set.
        send_point(32'sh0001_0000, 32'sh0001_0000, 1'b1);
        drain_results();
    endtask

    // Random point sets under random settings, with a given sender idle rate.
    task automatic test_random_sets(int items, int idle_pct);
        int sent;
        int set_size;
        logic [31:0] ridge;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < items) begin
            if ($urandom_range(2) == 0) begin
                drain_results();
                case ($urandom_range(3))
                    0: ridge = 0;
                    1: ridge = 32'hFFFF_FFFF;
                    default: ridge = $urandom_range(32'h0004_0000);
                endcase
                configure($urandom_range(1, 7), ridge, $urandom_range(1, 4),
                          $urandom_range(1) == 1);
            end
            set_size = $urandom_range(1, 6);
            for (int i = 0; i < set_size; i++)
                send_point(rand_sample(), rand_sample(), i == set_size - 1);
            sent += set_size;
        end
        drain_results();
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        x_value = 0;
        y_value = 0;
        last_point = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 0;
        cfg_data = 0;
        error_count = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        stored_points = 0;
        dropped_flag = 1'b0;
        degree_reg = 3;
        ridge_reg = 32'h0001_0000;
        cap_reg = 100;
        refine_reg = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_register_limits();
        test_store_full();
        test_random_sets(34, 28);
        test_random_sets(33, 54);
        test_random_sets(33, 0);

        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_coefs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
